// File: sv/sparsemax_weights_and_spmax_top_assert.svh
// Assertion macros used by the sparsemax datapath
`ifndef SPARSEMAX_WEIGHTS_AND_SPMAX_TOP_ASSERT_SVH
`define SPARSEMAX_WEIGHTS_AND_SPMAX_TOP_ASSERT_SVH

// same-cycle implication
`define SMX_AST_IMP(lbl, ck, rn, a, c) \
lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
	else $error("smx assertion failed");

// next-cycle implication
`define SMX_AST_NXT(lbl, ck, rn, a, c) \
lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
	else $error("smx assertion failed");

`endif

// File: sv/smx_pkg.sv
// Package: widths, constants and controller/datapath types for the sparsemax block
`default_nettype none
package smx_pkg;

	localparam int MAX_ITEMS_DEF = 16;
	localparam int VAL_W = 32;
	localparam int WT_W = 31;
	localparam int SPM_W = 48;
	localparam int WSUM_W = 47;
	localparam int FB_W = 2;
	localparam int RUN_W = 40;
	localparam int NUM_W = 41;
	localparam int WN = 40;
	localparam int SQ_W = 64;
	localparam int SSQ_W = 70;
	localparam int MW = 80;
	localparam int DEN_W = 24;
	localparam int DCNT_W = 7;
	localparam int UQ_W = 17;

	localparam logic [FB_W-1:0] FB_NONE = 2'd0;
	localparam logic [FB_W-1:0] FB_EMPTY = 2'd1;
	localparam logic [FB_W-1:0] FB_UNIFORM = 2'd2;

	localparam logic [UQ_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic signed [RUN_W-1:0] ONE_R = 40'sd65536;
	localparam logic signed [SPM_W-1:0] HALF_Q16 = 48'sd32768;
	localparam logic [SPM_W-1:0] SPM_MAX = {1'b0, {(SPM_W-1){1'b1}}};
	localparam logic [SPM_W-1:0] SPM_MIN = {1'b1, {(SPM_W-1){1'b0}}};
	localparam logic [WT_W-1:0] WT_MAX = {WT_W{1'b1}};

	typedef struct packed {
		logic wr;
		logic clr_count;
		logic prep;
		logic scan_start;
		logic scan_run;
		logic walk1;
		logic walk2;
		logic fb_empty;
		logic sq_start;
		logic sq_run;
		logic ksum_run;
		logic sp_div_start;
		logic sp_fin;
		logic w_mul;
		logic w_num;
		logic w_write;
		logic u_start;
		logic u_fin;
		logic e_load;
		logic e_next;
	} smx_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic k_zero;
		logic sq_done;
		logic ksum_done;
		logic div_done;
		logic num_pos;
		logic w_last;
		logic wsum_zero;
		logic e_last;
		logic out_fire;
	} smx_stat_t;

endpackage
`default_nettype wire

// File: sv/smx_if.sv
// Interfaces: input item channel and result channel
`default_nettype none
interface smx_in_if import smx_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] value;
	logic value_finite;
	logic has_child;
	logic last_item;
	modport source (output valid, value, value_finite, has_child, last_item, input ready);
	modport sink (input valid, value, value_finite, has_child, last_item, output ready);
endinterface

interface smx_out_if import smx_pkg::*; ();
	logic valid;
	logic ready;
	logic [3:0] item_index;
	logic [WT_W-1:0] weight;
	logic in_support;
	logic signed [SPM_W-1:0] spmax_value;
	logic [WSUM_W-1:0] weight_sum;
	logic [FB_W-1:0] fallback_used;
	logic last_result;
	modport source (output valid, item_index, weight, in_support, spmax_value, weight_sum,
		fallback_used, last_result, input ready);
	modport sink (input valid, item_index, weight, in_support, spmax_value, weight_sum,
		fallback_used, last_result, output ready);
endinterface
`default_nettype wire

// File: sv/smx_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none
module smx_div import smx_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [MW-1:0] num,
	input wire logic [DEN_W-1:0] den,
	input wire logic [DCNT_W-1:0] cnt,
	output logic busy,
	output logic [MW-1:0] quo,
	output logic rem_nz
);
	logic [DCNT_W-1:0] cnt_q;
	logic [MW-1:0] num_q, quo_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [DEN_W:0] trial, diff;
	logic ge;

	assign trial = {rem_q, num_q[MW-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};
	assign busy = cnt_q != '0;
	assign quo = quo_q;
	assign rem_nz = rem_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= cnt;
		end else if (busy) begin
			cnt_q <= cnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= num_q << 1;
			quo_q <= {quo_q[MW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// File: sv/smx_datapath.sv
// Datapath: item store, descending walk, spmax and weight arithmetic, result register
`default_nettype none
module smx_datapath import smx_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire smx_cmd_t cmd,
	output smx_stat_t stat,
	input wire logic children_only,
	input wire logic signed [VAL_W-1:0] in_value,
	input wire logic in_finite,
	input wire logic in_has_child,
	input wire logic out_ready,
	output logic out_valid,
	output logic [3:0] item_index,
	output logic [WT_W-1:0] weight,
	output logic in_support,
	output logic signed [SPM_W-1:0] spmax_value,
	output logic [WSUM_W-1:0] weight_sum,
	output logic [FB_W-1:0] fallback_used,
	output logic last_result
);
`include "sparsemax_weights_and_spmax_top_assert.svh"

	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int MEM_W = VAL_W + 2;

	logic [MEM_W-1:0] mem [MAX_ITEMS];
	logic [WT_W-1:0] wmem [MAX_ITEMS];
	logic [MEM_W-1:0] rdata_q;
	logic [WT_W-1:0] wrdata_q;
	logic [CW-1:0] cnt_q, scan_a_q, ecnt_q, k_q, kcnt_q;
	logic [IW-1:0] widx_q, eidx_q, pidx_s1, best_idx_q, raddr;
	logic pend_s1, found_q;
	logic signed [VAL_W-1:0] best_v_q;
	logic [MAX_ITEMS-1:0] taken_q, supp_q;
	logic signed [RUN_W-1:0] run_q, s_q, prod_s1, kv_s1;
	logic [SQ_W-1:0] sq_s1;
	logic [SSQ_W-1:0] sumsq_q;
	logic [MW-1:0] a_q, sqacc_q, macc_q;
	logic [RUN_W-1:0] b_q;
	logic neg_q, fin_s1, w_pos_q;
	logic signed [SPM_W-1:0] spmax_q;
	logic [WSUM_W-1:0] wsum_q;
	logic [FB_W-1:0] fb_q;
	logic [UQ_W-1:0] uq_q;

	logic out_valid_q, in_support_q, last_q;
	logic [3:0] idx_out_q;
	logic [WT_W-1:0] weight_q;
	logic signed [SPM_W-1:0] spmax_out_q;
	logic [WSUM_W-1:0] wsum_out_q;
	logic [FB_W-1:0] fb_out_q;

	logic signed [VAL_W-1:0] r_v;
	logic r_fin, r_hc, r_elig, wr_en;
	logic [VAL_W-1:0] mag;
	logic [CW-1:0] ep1;
	logic signed [RUN_W-1:0] ep1_x, v_x, rv_x, k_x, d, s_m1;
	logic [RUN_W-1:0] dm;
	logic [MW-1:0] mval, mmag, qq;
	logic signed [NUM_W-1:0] num;
	logic num_pos;
	logic div_start, div_busy, rem_nz;
	logic [MW-1:0] dnum, quo;
	logic [DEN_W-1:0] dden;
	logic [DCNT_W-1:0] dcnt;
	logic [WT_W-1:0] wq, wt_new, emit_wt;
	logic [IW+3:0] eidx_x;

	assign r_v = rdata_q[VAL_W-1:0];
	assign r_fin = rdata_q[VAL_W];
	assign r_hc = rdata_q[VAL_W+1];
	assign r_elig = r_fin && (!children_only || r_hc);
	assign wr_en = cmd.wr && (cnt_q != CW'(MAX_ITEMS));
	assign raddr = cmd.scan_run ? scan_a_q[IW-1:0] : widx_q;

	assign mag = best_v_q[VAL_W-1] ? VAL_W'(-best_v_q) : VAL_W'(best_v_q);
	assign ep1 = ecnt_q + CW'(1);
	assign ep1_x = RUN_W'(ep1);
	assign v_x = RUN_W'(best_v_q);
	assign rv_x = RUN_W'(r_v);
	assign k_x = RUN_W'(k_q);
	assign s_m1 = s_q - ONE_R;
	assign d = s_m1;
	assign dm = d[RUN_W-1] ? RUN_W'(-d) : RUN_W'(d);
	assign mval = macc_q - sqacc_q;
	assign mmag = mval[MW-1] ? -mval : mval;
	assign qq = quo + MW'(rem_nz);
	assign num = NUM_W'(kv_s1) - NUM_W'(s_m1);
	assign num_pos = fin_s1 && !num[NUM_W-1] && (num != '0);
	assign wq = (quo > MW'(WT_MAX)) ? WT_MAX : quo[WT_W-1:0];
	assign wt_new = w_pos_q ? wq : '0;
	assign eidx_x = (IW+4)'(eidx_q);

	assign div_start = cmd.sp_div_start || (cmd.w_num && num_pos) || cmd.u_start;

	always_comb begin
		if (cmd.sp_div_start) begin
			dnum = mmag;
			dden = DEN_W'(k_q) << 17;
			dcnt = DCNT_W'(MW);
		end else if (cmd.w_num) begin
			dnum = {num[WN-1:0], {(MW-WN){1'b0}}};
			dden = DEN_W'(k_q);
			dcnt = DCNT_W'(WN);
		end else begin
			dnum = {ONE_Q16, {(MW-UQ_W){1'b0}}};
			dden = DEN_W'(cnt_q);
			dcnt = DCNT_W'(UQ_W);
		end
	end

	smx_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(dnum),
		.den(dden),
		.cnt(dcnt),
		.busy(div_busy),
		.quo(quo),
		.rem_nz(rem_nz)
	);

	always_comb begin
		case (fb_q)
			FB_EMPTY: emit_wt = WT_W'(ONE_Q16);
			FB_UNIFORM: emit_wt = WT_W'(uq_q);
			default: emit_wt = wrdata_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IW-1:0]] <= {in_has_child, in_finite, in_value};
		end
		rdata_q <= mem[raddr];
		if (cmd.w_write) begin
			wmem[widx_q] <= wt_new;
		end
		wrdata_q <= wmem[eidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			scan_a_q <= '0;
			pend_s1 <= 1'b0;
			found_q <= 1'b0;
			ecnt_q <= '0;
			k_q <= '0;
			kcnt_q <= '0;
			widx_q <= '0;
			eidx_q <= '0;
			taken_q <= '0;
			supp_q <= '0;
			b_q <= '0;
			fb_q <= FB_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.clr_count) begin
				cnt_q <= '0;
			end
			if (cmd.prep) begin
				taken_q <= '0;
				supp_q <= '0;
				ecnt_q <= '0;
				k_q <= '0;
				eidx_q <= '0;
			end
			if (cmd.scan_start) begin
				scan_a_q <= '0;
				pend_s1 <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan_run) begin
				if (scan_a_q != cnt_q) begin
					scan_a_q <= scan_a_q + CW'(1);
					pend_s1 <= 1'b1;
				end else begin
					pend_s1 <= 1'b0;
				end
				if (pend_s1 && r_elig && !taken_q[pidx_s1] && (!found_q || r_v >= best_v_q)) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.walk1) begin
				taken_q[best_idx_q] <= 1'b1;
			end
			if (cmd.walk2) begin
				ecnt_q <= ep1;
				if ((ONE_R + prod_s1) > run_q) begin
					supp_q[best_idx_q] <= 1'b1;
					k_q <= k_q + CW'(1);
				end
			end
			if (cmd.sq_start) begin
				b_q <= dm;
				kcnt_q <= k_q;
			end else if (cmd.sq_run) begin
				b_q <= b_q >> 1;
			end
			if (cmd.ksum_run && kcnt_q != '0) begin
				kcnt_q <= kcnt_q - CW'(1);
			end
			if (cmd.sp_fin) begin
				fb_q <= FB_NONE;
				widx_q <= '0;
			end
			if (cmd.fb_empty) begin
				fb_q <= FB_EMPTY;
			end
			if (cmd.u_fin) begin
				fb_q <= FB_UNIFORM;
			end
			if (cmd.w_write) begin
				widx_q <= widx_q + IW'(1);
			end
			if (cmd.e_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.e_next) begin
				eidx_q <= eidx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run) begin
			pidx_s1 <= scan_a_q[IW-1:0];
			if (pend_s1 && r_elig && !taken_q[pidx_s1] && (!found_q || r_v >= best_v_q)) begin
				best_v_q <= r_v;
				best_idx_q <= pidx_s1;
			end
		end
		if (cmd.prep) begin
			run_q <= '0;
			s_q <= '0;
			sumsq_q <= '0;
		end
		if (cmd.walk1) begin
			run_q <= run_q + v_x;
			prod_s1 <= RUN_W'(ep1_x * v_x);
			sq_s1 <= SQ_W'(mag) * SQ_W'(mag);
		end
		if (cmd.walk2 && ((ONE_R + prod_s1) > run_q)) begin
			s_q <= s_q + v_x;
			sumsq_q <= sumsq_q + SSQ_W'(sq_s1);
		end
		if (cmd.sq_start) begin
			a_q <= MW'(dm);
			sqacc_q <= '0;
			macc_q <= MW'(k_q) << 32;
		end else if (cmd.sq_run) begin
			if (b_q[0]) begin
				sqacc_q <= sqacc_q + a_q;
			end
			a_q <= a_q << 1;
		end
		if (cmd.ksum_run && kcnt_q != '0) begin
			macc_q <= macc_q + MW'(sumsq_q);
		end
		if (cmd.sp_div_start) begin
			neg_q <= mval[MW-1];
		end
		if (cmd.sp_fin) begin
			wsum_q <= '0;
			if (neg_q) begin
				spmax_q <= (qq > MW'(SPM_MIN)) ? SPM_MIN : SPM_W'(-qq);
			end else begin
				spmax_q <= (quo > MW'(SPM_MAX)) ? SPM_MAX : quo[SPM_W-1:0];
			end
		end
		if (cmd.fb_empty) begin
			spmax_q <= HALF_Q16;
			wsum_q <= WSUM_W'(cnt_q) << 16;
		end
		if (cmd.w_mul) begin
			kv_s1 <= RUN_W'(k_x * rv_x);
			fin_s1 <= r_fin;
		end
		if (cmd.w_num) begin
			w_pos_q <= num_pos;
		end
		if (cmd.w_write) begin
			wsum_q <= wsum_q + WSUM_W'(wt_new);
		end
		if (cmd.u_fin) begin
			uq_q <= quo[UQ_W-1:0];
			wsum_q <= WSUM_W'(cnt_q) * WSUM_W'(quo[UQ_W-1:0]);
		end
		if (cmd.e_load) begin
			idx_out_q <= eidx_x[3:0];
			weight_q <= emit_wt;
			in_support_q <= supp_q[eidx_q];
			spmax_out_q <= spmax_q;
			wsum_out_q <= wsum_q;
			fb_out_q <= fb_q;
			last_q <= (CW'(eidx_q) + CW'(1)) == cnt_q;
		end
	end

	assign stat.scan_done = (scan_a_q == cnt_q) && !pend_s1;
	assign stat.found = found_q;
	assign stat.k_zero = k_q == '0;
	assign stat.sq_done = b_q == '0;
	assign stat.ksum_done = kcnt_q == '0;
	assign stat.div_done = !div_busy;
	assign stat.num_pos = num_pos;
	assign stat.w_last = (CW'(widx_q) + CW'(1)) == cnt_q;
	assign stat.wsum_zero = wsum_q == '0;
	assign stat.e_last = (CW'(eidx_q) + CW'(1)) == cnt_q;
	assign stat.out_fire = out_valid_q && out_ready;

	assign out_valid = out_valid_q;
	assign item_index = idx_out_q;
	assign weight = weight_q;
	assign in_support = in_support_q;
	assign spmax_value = spmax_out_q;
	assign weight_sum = wsum_out_q;
	assign fallback_used = fb_out_q;
	assign last_result = last_q;

	`SMX_AST_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(MAX_ITEMS))
	`SMX_AST_IMP(a_k_supp, clk, arst_n, k_q == '0, supp_q == '0)
	`SMX_AST_IMP(a_div_idle, clk, arst_n, div_start, !div_busy)
	`SMX_AST_IMP(a_last_idx, clk, arst_n, out_valid_q && last_q, stat.e_last)
endmodule
`default_nettype wire

// File: sv/smx_ctrl.sv
// Controller: sequences load, walk, spmax, weight and emit phases
`default_nettype none
module smx_ctrl import smx_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic in_last,
	input wire smx_stat_t stat,
	output smx_cmd_t cmd,
	output logic in_ready
);
	typedef enum logic [23:0] {
		S_LOAD    = 24'h000001,
		S_PREP    = 24'h000002,
		S_SCAN_ST = 24'h000004,
		S_SCAN    = 24'h000008,
		S_WALK1   = 24'h000010,
		S_WALK2   = 24'h000020,
		S_SP_ST   = 24'h000040,
		S_SQ      = 24'h000080,
		S_KSUM    = 24'h000100,
		S_SP_DIV  = 24'h000200,
		S_SP_WAIT = 24'h000400,
		S_SP_FIN  = 24'h000800,
		S_W_RD    = 24'h001000,
		S_W_MUL   = 24'h002000,
		S_W_NUM   = 24'h004000,
		S_W_DIV   = 24'h008000,
		S_W_WR    = 24'h010000,
		S_W_CHK   = 24'h020000,
		S_U_DIV   = 24'h040000,
		S_U_WAIT  = 24'h080000,
		S_U_FIN   = 24'h100000,
		S_E_RD    = 24'h200000,
		S_E_LD    = 24'h400000,
		S_E_WAIT  = 24'h800000
	} smx_state_t;

	smx_state_t state_q, state_d;

	assign in_ready = state_q == S_LOAD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				cmd.wr = in_fire;
				if (in_fire && in_last) state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d = S_SCAN_ST;
			end
			S_SCAN_ST: begin
				cmd.scan_start = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) state_d = stat.found ? S_WALK1 : S_SP_ST;
			end
			S_WALK1: begin
				cmd.walk1 = 1'b1;
				state_d = S_WALK2;
			end
			S_WALK2: begin
				cmd.walk2 = 1'b1;
				state_d = S_SCAN_ST;
			end
			S_SP_ST: begin
				if (stat.k_zero) begin
					cmd.fb_empty = 1'b1;
					state_d = S_E_RD;
				end else begin
					cmd.sq_start = 1'b1;
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				cmd.sq_run = 1'b1;
				if (stat.sq_done) state_d = S_KSUM;
			end
			S_KSUM: begin
				cmd.ksum_run = 1'b1;
				if (stat.ksum_done) state_d = S_SP_DIV;
			end
			S_SP_DIV: begin
				cmd.sp_div_start = 1'b1;
				state_d = S_SP_WAIT;
			end
			S_SP_WAIT: begin
				if (stat.div_done) state_d = S_SP_FIN;
			end
			S_SP_FIN: begin
				cmd.sp_fin = 1'b1;
				state_d = S_W_RD;
			end
			S_W_RD: begin
				state_d = S_W_MUL;
			end
			S_W_MUL: begin
				cmd.w_mul = 1'b1;
				state_d = S_W_NUM;
			end
			S_W_NUM: begin
				cmd.w_num = 1'b1;
				state_d = stat.num_pos ? S_W_DIV : S_W_WR;
			end
			S_W_DIV: begin
				if (stat.div_done) state_d = S_W_WR;
			end
			S_W_WR: begin
				cmd.w_write = 1'b1;
				state_d = stat.w_last ? S_W_CHK : S_W_RD;
			end
			S_W_CHK: begin
				state_d = stat.wsum_zero ? S_U_DIV : S_E_RD;
			end
			S_U_DIV: begin
				cmd.u_start = 1'b1;
				state_d = S_U_WAIT;
			end
			S_U_WAIT: begin
				if (stat.div_done) state_d = S_U_FIN;
			end
			S_U_FIN: begin
				cmd.u_fin = 1'b1;
				state_d = S_E_RD;
			end
			S_E_RD: begin
				state_d = S_E_LD;
			end
			S_E_LD: begin
				cmd.e_load = 1'b1;
				state_d = S_E_WAIT;
			end
			S_E_WAIT: begin
				if (stat.out_fire) begin
					cmd.e_next = 1'b1;
					if (stat.e_last) begin
						cmd.clr_count = 1'b1;
						state_d = S_LOAD;
					end else begin
						state_d = S_E_RD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end
endmodule
`default_nettype wire

// File: sv/sparsemax_weights_and_spmax_top.sv
// Loading: one word per cycle in the load phase; the word that closes the set starts the run.
// Walk: one scan pass over the items per eligible item, plus a final pass that finds none.
// Spmax: bit-serial square of |S-1|, k accumulations, then a divide by k<<17.
// Weights: read, multiply, numerator, write per item; shared divider if numerator > 0.
// Emit: each result held until the sink takes it; new items are taken after the last.
// Reset: asynchronous, clears control, count and configuration; item stores stay undefined.
`default_nettype none
module sparsemax_weights_and_spmax_top import smx_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	smx_in_if.sink items,
	smx_out_if.source results,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic children_only_q;
	logic in_ready, in_fire;
	smx_cmd_t cmd;
	smx_stat_t stat;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {31'd0, children_only_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			children_only_q <= 1'b0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			children_only_q <= pwdata[0];
		end
	end

	assign items.ready = in_ready;
	assign in_fire = items.valid && in_ready;

	smx_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.in_last(items.last_item),
		.stat(stat),
		.cmd(cmd),
		.in_ready(in_ready)
	);

	smx_datapath #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.children_only(children_only_q),
		.in_value(items.value),
		.in_finite(items.value_finite),
		.in_has_child(items.has_child),
		.out_ready(results.ready),
		.out_valid(results.valid),
		.item_index(results.item_index),
		.weight(results.weight),
		.in_support(results.in_support),
		.spmax_value(results.spmax_value),
		.weight_sum(results.weight_sum),
		.fallback_used(results.fallback_used),
		.last_result(results.last_result)
	);
endmodule
`default_nettype wire
